@@ rtl/core/ccem_pkg.sv @@
package ccem_pkg;

  localparam int unsigned CLW = 28;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_REPLY  = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_NEED    = 3'd0,
    ST_DONE    = 3'd1,
    ST_CHAIN   = 3'd2,
    ST_FRAG    = 3'd3,
    ST_READ    = 3'd4,
    ST_HIT     = 3'd5,
    ST_MISS    = 3'd6,
    ST_IGNORED = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    REG_DATA_START = 2'd0,
    REG_FAT_START  = 2'd1,
    REG_CLU_SECT   = 2'd2,
    REG_CLU_TOTAL  = 2'd3
  } reg_idx_t;

  localparam logic [CLW-1:0] ENTRY_MASK = 28'hFFFFFFF;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] fat_lba;
    logic [8:0]  fat_byte_offset;
    logic [5:0]  extent_total;
    logic [31:0] mapped_sectors;
    logic [31:0] hit_lba;
    logic [31:0] hit_run;
  } result_t;

endpackage

@@ rtl/core/ccem_ext_mem.sv @@
module ccem_ext_mem
  import ccem_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  logic [CLW-1:0] wr_start,
  input  logic [CLW-1:0] wr_len,
  input  logic [AW-1:0]  rd_addr,
  output logic [CLW-1:0] rd_start,
  output logic [CLW-1:0] rd_len
);

  logic [2*CLW-1:0] mem [DEPTH];
  logic [2*CLW-1:0] rd_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_len, wr_start};
    end
    rd_q <= mem[rd_addr];
  end

  assign rd_start = rd_q[CLW-1:0];
  assign rd_len   = rd_q[2*CLW-1:CLW];

endmodule

@@ rtl/core/cluster_chain_extent_mapper.sv @@
// A start that ends at once, an ignored beat or an early lookup miss goes straight to the result
// stage (S_REQ, S_OUT); a start that opens a walk passes through S_PREP and S_ADV first. A reply
// either fails or, once the extent memory scan is through, extends the run or opens a new one.
// A lookup scans the extent memory for the extent that holds the query offset.
// One beat is in work at a time: no new input is taken until the result has been accepted.
// Reset (rst_n low, synchronous) clears walk state, counts and registers; the memory is kept.
module cluster_chain_extent_mapper
  import ccem_pkg::*;
#(
  parameter int unsigned MAX_EXT = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation
  input  logic [1:0]   in_tuser,
  // start cluster, size_bytes, entry_raw, entry_read_bad, query_offset, pad
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status
  output logic [2:0]   out_tuser,
  // fat_lba, fat_byte_offset, extent_total, mapped_sectors, hit_lba, hit_run, pad
  output logic [143:0] out_tdata,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int unsigned AW = (MAX_EXT > 1) ? $clog2(MAX_EXT) : 1;
  localparam int unsigned CW = $clog2(MAX_EXT + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_SCAN, S_ADV, S_REQ, S_OUT
  } state_t;

  state_t state_r;
  logic [31:0] data_start_r, fat_start_r;
  logic [7:0]  clu_sect_r;
  logic [CLW-1:0] clu_total_r;

  logic [CW-1:0]  ext_count_r;
  logic [31:0]    sector_sum_r;
  logic [CLW-1:0] cur_r, run_first_r, run_count_r, step_r;
  logic [23:0]    needed_r;
  logic           walking_r;

  logic [1:0]     op_r;
  logic [CLW-1:0] next_r;
  logic           bad_r;
  logic [31:0]    q_r;
  logic [CW-1:0]  idx_r;
  logic [31:0]    base_r;
  logic           found_r;
  logic [35:0]    run_sect_r;
  result_t        res_r;

  logic [CLW-1:0] mem_start, mem_len;
  logic           wr_en;
  logic [AW-1:0]  rd_addr;
  logic [CW-1:0]  idx_inc;

  logic [1:0]  in_op;
  logic [31:0] in_start, in_size, in_raw, in_q;
  logic        in_bad;
  assign in_op    = in_tuser;
  assign in_start = in_tdata[31:0];
  assign in_size  = in_tdata[63:32];
  assign in_raw   = in_tdata[95:64];
  assign in_bad   = in_tdata[96];
  assign in_q     = in_tdata[128:97];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tuser  = res_r.status;
  assign out_tdata  = {1'b0, res_r.hit_run, res_r.hit_lba, res_r.mapped_sectors,
                       res_r.extent_total, res_r.fat_byte_offset, res_r.fat_lba};

  logic accept;
  assign accept = in_tvalid && in_tready;

  logic table_full;
  assign table_full = (ext_count_r >= CW'(MAX_EXT));

  assign wr_en = (state_r == S_ADV) && walking_r && !table_full &&
                 (found_r || ({4'd0, sector_sum_r} + run_sect_r >= {12'd0, needed_r}));
  assign idx_inc = idx_r + CW'(1);
  assign rd_addr = (state_r == S_IDLE) ? '0 : idx_inc[AW-1:0];

  ccem_ext_mem #(.DEPTH(MAX_EXT), .AW(AW)) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (ext_count_r[AW-1:0]),
    .wr_start (run_first_r),
    .wr_len   (run_count_r),
    .rd_addr  (rd_addr),
    .rd_start (mem_start),
    .rd_len   (mem_len)
  );

  function automatic logic clu_ok(input logic [CLW-1:0] c, input logic [CLW-1:0] tot);
    clu_ok = (c >= CLW'(2)) && ({1'b0, c} < ({1'b0, tot} + 29'd2));
  endfunction

  logic start_ok;
  assign start_ok = (in_start[31:CLW] == '0) && clu_ok(in_start[CLW-1:0], clu_total_r);

  status_t idle_st;
  always_comb begin
    case (in_op)
      OP_START:  idle_st = (in_size == 32'd0) ? ST_DONE : ST_CHAIN;
      OP_LOOKUP: idle_st = ST_MISS;
      default:   idle_st = ST_IGNORED;
    endcase
  end

  logic [59:0] mem_end;
  logic [35:0] mem_sect;
  assign mem_end  = {32'd0, mem_start} + {32'd0, mem_len};
  assign mem_sect = 36'(mem_len) * 36'(clu_sect_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      data_start_r <= '0;
      fat_start_r  <= '0;
      clu_sect_r   <= 8'd1;
      clu_total_r  <= CLW'(1);
      ext_count_r  <= '0;
      sector_sum_r <= '0;
      cur_r        <= '0;
      run_first_r  <= '0;
      run_count_r  <= '0;
      step_r       <= '0;
      needed_r     <= '0;
      walking_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_DATA_START: data_start_r <= cfg_data;
          REG_FAT_START:  fat_start_r  <= cfg_data;
          REG_CLU_SECT:   clu_sect_r   <= cfg_data[7:0];
          REG_CLU_TOTAL:  clu_total_r  <= cfg_data[CLW-1:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r    <= in_op;
            next_r  <= in_raw[CLW-1:0] & ENTRY_MASK;
            bad_r   <= in_bad;
            q_r     <= in_q;
            idx_r   <= '0;
            base_r  <= '0;
            found_r <= 1'b0;
            res_r   <= {idle_st, 143'd0};
            case (in_op)
              OP_START: begin
                ext_count_r  <= '0;
                sector_sum_r <= '0;
                if (in_size == 32'd0) begin
                  walking_r <= 1'b0;
                  state_r <= S_REQ;
                end else if (!start_ok) begin
                  walking_r <= 1'b0;
                  state_r <= S_REQ;
                end else begin
                  needed_r    <= 24'(({1'b0, in_size} + 33'd511) >> 9);
                  cur_r       <= in_start[CLW-1:0];
                  run_first_r <= in_start[CLW-1:0];
                  run_count_r <= CLW'(1);
                  step_r      <= '0;
                  walking_r   <= 1'b1;
                  state_r     <= S_PREP;
                end
              end
              OP_REPLY: begin
                if (!walking_r) begin
                  state_r <= S_REQ;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              OP_LOOKUP: begin
                if (in_q < sector_sum_r && ext_count_r != '0) begin
                  state_r <= S_SCAN;
                end else begin
                  state_r <= S_REQ;
                end
              end
              default: state_r <= S_REQ;
            endcase
          end
        end
        S_SCAN: begin
          if (op_r == OP_REPLY) begin
            if (bad_r) begin
              walking_r <= 1'b0;
              res_r.status <= ST_READ;
              state_r <= S_REQ;
            end else if (!clu_ok(next_r, clu_total_r) ||
                         (next_r >= run_first_r &&
                          {1'b0, next_r} < {1'b0, run_first_r} + {1'b0, run_count_r}) ||
                         (ext_count_r != '0 && next_r >= mem_start &&
                          {32'd0, next_r} < mem_end)) begin
              walking_r <= 1'b0;
              res_r.status <= ST_CHAIN;
              state_r <= S_REQ;
            end else if (idx_inc < ext_count_r) begin
              idx_r <= idx_inc;
            end else if (next_r == cur_r + CLW'(1)) begin
              run_count_r <= run_count_r + CLW'(1);
              cur_r <= next_r;
              state_r <= S_PREP;
            end else if (table_full) begin
              walking_r <= 1'b0;
              res_r.status <= ST_FRAG;
              state_r <= S_REQ;
            end else begin
              found_r <= 1'b1;
              run_sect_r <= 36'(run_count_r) * 36'(clu_sect_r);
              state_r <= S_ADV;
            end
          end else begin
            if ({4'd0, q_r} < {4'd0, base_r} + mem_sect) begin
              res_r.status <= ST_HIT;
              res_r.hit_lba <= data_start_r +
                32'(mem_start - CLW'(2)) * {24'd0, clu_sect_r} + (q_r - base_r);
              res_r.hit_run <= 32'(({4'd0, base_r} + mem_sect) - {4'd0, q_r});
              state_r <= S_REQ;
            end else if (idx_inc < ext_count_r) begin
              base_r <= base_r + 32'(mem_sect);
              idx_r <= idx_inc;
            end else begin
              state_r <= S_REQ;
            end
          end
        end
        S_PREP: begin
          run_sect_r <= 36'(run_count_r) * 36'(clu_sect_r);
          found_r <= 1'b0;
          state_r <= S_ADV;
        end
        S_ADV: begin
          if (found_r) begin
            // Close the old run, open a new one at the next cluster.
            ext_count_r  <= ext_count_r + CW'(1);
            sector_sum_r <= sector_sum_r + run_sect_r[31:0];
            run_first_r  <= next_r;
            run_count_r  <= CLW'(1);
            cur_r        <= next_r;
            state_r      <= S_PREP;
          end else if ({4'd0, sector_sum_r} + run_sect_r >= {12'd0, needed_r}) begin
            walking_r <= 1'b0;
            if (table_full) begin
              res_r.status <= ST_FRAG;
            end else begin
              res_r.status <= ST_DONE;
              ext_count_r  <= ext_count_r + CW'(1);
              sector_sum_r <= sector_sum_r + run_sect_r[31:0];
            end
            state_r <= S_REQ;
          end else if (step_r + CLW'(1) > clu_total_r || step_r == ENTRY_MASK) begin
            step_r <= step_r + CLW'(1);
            walking_r <= 1'b0;
            res_r.status <= ST_CHAIN;
            state_r <= S_REQ;
          end else begin
            step_r <= step_r + CLW'(1);
            res_r.status <= ST_NEED;
            res_r.fat_lba <= fat_start_r + {11'd0, cur_r[CLW-1:7]};
            res_r.fat_byte_offset <= {cur_r[6:0], 2'b00};
            state_r <= S_REQ;
          end
        end
        S_REQ: begin
          res_r.extent_total   <= 6'(ext_count_r);
          res_r.mapped_sectors <= sector_sum_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ext_count_r <= CW'(MAX_EXT)) else $error("extent count overflow");
  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !table_full) else $error("write into full table");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(res_r)) else $error("result dropped");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");

endmodule
